>>> sv/baro_temp_pressure_compensation_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation pipeline
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define BTPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define BTPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BTPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/btpc_pkg.sv
// ----------------------------------------------------------------------------
// Package of the barometric compensation pipeline
// Field widths, register indexes and shared beat types.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int unsigned RAW_W = 20;
    localparam int unsigned CAL_W = 48;
    localparam int unsigned IDX_W = 2;
    localparam int unsigned TEMP_W = 16;
    localparam int unsigned PRES_W = 25;
    localparam int unsigned DIV_LATENCY = 64;

    typedef enum logic [IDX_W-1:0] {
        REG_CAL_TEMP    = 2'd0,
        REG_CAL_PRESS_A = 2'd1,
        REG_CAL_PRESS_B = 2'd2,
        REG_CAL_PRESS_C = 2'd3
    } t_reg_idx;

    // Beat handed from the front end to the divider.
    typedef struct packed {
        logic                     vld;
        logic signed [TEMP_W-1:0] temp;
        logic                     zero;
        logic [63:0]              num;
        logic [63:0]              den;
    } t_front_beat;

    // Beat handed from the divider to the back end.
    typedef struct packed {
        logic                     vld;
        logic signed [TEMP_W-1:0] temp;
        logic                     zero;
        logic [63:0]              quo;
    } t_div_beat;

endpackage

>>> sv/btpc_front.sv
// ----------------------------------------------------------------------------
// Front end of the compensation pipeline
// Fine temperature, temperature output and the pressure numerator and divisor,
// cut into six registered stages with at most three multipliers each.
// ----------------------------------------------------------------------------
module btpc_front
    import btpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [RAW_W-1:0]    i_pressure_raw,
    input  logic [RAW_W-1:0]    i_temperature_raw,
    input  logic [CAL_W-1:0]    i_cal_temp,
    input  logic [CAL_W-1:0]    i_cal_press_a,
    input  logic [CAL_W-1:0]    i_cal_press_b,
    output t_front_beat         o_beat
);

    // Coefficients, widened: T to 32 bits, P to 64; T1 and P1 are unsigned.
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6;

    assign t1 = {16'd0, i_cal_temp[15:0]};
    assign t2 = {{16{i_cal_temp[31]}}, i_cal_temp[31:16]};
    assign t3 = {{16{i_cal_temp[47]}}, i_cal_temp[47:32]};
    assign p1 = {48'd0, i_cal_press_a[15:0]};
    assign p2 = {{48{i_cal_press_a[31]}}, i_cal_press_a[31:16]};
    assign p3 = {{48{i_cal_press_a[47]}}, i_cal_press_a[47:32]};
    assign p4 = {{48{i_cal_press_b[15]}}, i_cal_press_b[15:0]};
    assign p5 = {{48{i_cal_press_b[31]}}, i_cal_press_b[31:16]};
    assign p6 = {{48{i_cal_press_b[47]}}, i_cal_press_b[47:32]};

    // Stage 1: differences and first products.
    logic        r_v1;
    logic [31:0] r_a_t2, r_d_d;
    logic [RAW_W-1:0] r_p1_raw;
    logic [31:0] n_a, n_d;

    assign n_a = {15'd0, i_temperature_raw[RAW_W-1:3]} - {t1[30:0], 1'b0};
    assign n_d = {16'd0, i_temperature_raw[RAW_W-1:4]} - t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
        end
        r_a_t2   <= n_a * t2;
        r_d_d    <= n_d * n_d;
        r_p1_raw <= i_pressure_raw;
    end

    // Stage 2: second temperature product.
    logic        r_v2;
    logic [31:0] r_tv1, r_dd_t3;
    logic [RAW_W-1:0] r_p2_raw;
    logic [31:0] n_dds;

    assign n_dds = 32'($signed(r_d_d) >>> 12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_tv1    <= 32'($signed(r_a_t2) >>> 11);
        r_dd_t3  <= n_dds * t3;
        r_p2_raw <= r_p1_raw;
    end

    // Stage 3: fine temperature, temperature output, v1.
    // v1 is the fine temperature minus 128000, which always fits in 33 bits.
    logic        r_v3;
    logic signed [32:0] r_v1v;
    logic signed [TEMP_W-1:0] r_temp3;
    logic [RAW_W-1:0] r_p3_raw;
    logic [31:0] n_tfine;
    logic [63:0] n_tf, n_tc;

    assign n_tfine = r_tv1 + 32'($signed(r_dd_t3) >>> 14);
    assign n_tf    = {{32{n_tfine[31]}}, n_tfine};
    assign n_tc    = 64'($signed(n_tf * 64'd5 + 64'd128) >>> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_v1v <= n_tf[32:0] - 33'd128000;
        if ($signed(n_tc) > 64'sd32767) begin
            r_temp3 <= 16'sh7fff;
        end else if ($signed(n_tc) < -64'sd32768) begin
            r_temp3 <= 16'sh8000;
        end else begin
            r_temp3 <= n_tc[15:0];
        end
        r_p3_raw <= r_p2_raw;
    end

    // Stage 4: square and linear terms of v1.
    logic        r_v4;
    logic [63:0] r_sq, r_v1p5, r_v1p2;
    logic signed [TEMP_W-1:0] r_temp4;
    logic [RAW_W-1:0] r_p4_raw;
    logic [63:0] n_v1w;
    logic signed [65:0] n_sq;

    assign n_v1w = {{31{r_v1v[32]}}, r_v1v};
    assign n_sq  = r_v1v * r_v1v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_sq     <= n_sq[63:0];
        r_v1p5   <= n_v1w * p5;
        r_v1p2   <= n_v1w * p2;
        r_temp4  <= r_temp3;
        r_p4_raw <= r_p3_raw;
    end

    // Stage 5: products with the square.
    logic        r_v5;
    logic [63:0] r_v2a, r_v1b;
    logic signed [TEMP_W-1:0] r_temp5;
    logic [RAW_W-1:0] r_p5_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_v2a    <= r_sq * p6 + (r_v1p5 << 17) + (p4 << 35);
        r_v1b    <= 64'($signed(r_sq * p3) >>> 8) + (r_v1p2 << 12);
        r_temp5  <= r_temp4;
        r_p5_raw <= r_p4_raw;
    end

    // Stage 6: divisor and numerator.
    logic [63:0] n_den, n_p;

    assign n_den = 64'($signed(((64'd1 << 47) + r_v1b) * p1) >>> 33);
    assign n_p   = 64'd1048576 - {44'd0, r_p5_raw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_beat.vld <= 1'b0;
        end else begin
            o_beat.vld <= r_v5;
        end
        o_beat.temp <= r_temp5;
        o_beat.den  <= n_den;
        o_beat.zero <= (n_den == 64'd0);
        o_beat.num  <= ((n_p << 31) - r_v2a) * 64'd3125;
    end

endmodule

>>> sv/btpc_div.sv
// ----------------------------------------------------------------------------
// Pipelined signed 64-bit divider
// One restoring quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module btpc_div
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_front_beat i_beat,
    output t_div_beat   o_beat
);

    logic [DIV_LATENCY:0]    r_vld;
    logic [DIV_LATENCY:0]    r_zero;
    logic [DIV_LATENCY:0]    r_neg;
    logic [TEMP_W-1:0]       r_temp [DIV_LATENCY+1];
    logic [63:0]             r_rem  [DIV_LATENCY+1];
    logic [63:0]             r_quo  [DIV_LATENCY+1];
    logic [63:0]             r_dsr  [DIV_LATENCY+1];

    // Entry stage: magnitudes and result sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_beat.vld;
        end
        r_zero[0] <= i_beat.zero;
        r_neg[0]  <= i_beat.num[63] ^ i_beat.den[63];
        r_temp[0] <= i_beat.temp;
        r_rem[0]  <= 64'd0;
        r_quo[0]  <= i_beat.num[63] ? 64'd0 - i_beat.num : i_beat.num;
        r_dsr[0]  <= i_beat.den[63] ? 64'd0 - i_beat.den : i_beat.den;
    end

    for (genvar g = 0; g < DIV_LATENCY; g++) begin : g_step
        logic [64:0] n_trial;
        logic [64:0] n_sh;
        assign n_sh    = {r_rem[g], r_quo[g][63]};
        assign n_trial = n_sh - {1'b0, r_dsr[g]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_zero[g+1] <= r_zero[g];
            r_neg[g+1]  <= r_neg[g];
            r_temp[g+1] <= r_temp[g];
            r_dsr[g+1]  <= r_dsr[g];
            if (!n_trial[64]) begin
                r_rem[g+1] <= n_trial[63:0];
                r_quo[g+1] <= {r_quo[g][62:0], 1'b1};
            end else begin
                r_rem[g+1] <= n_sh[63:0];
                r_quo[g+1] <= {r_quo[g][62:0], 1'b0};
            end
        end
    end

    always_comb begin
        o_beat.vld  = r_vld[DIV_LATENCY];
        o_beat.zero = r_zero[DIV_LATENCY];
        o_beat.temp = r_temp[DIV_LATENCY];
        o_beat.quo  = r_neg[DIV_LATENCY] ? 64'd0 - r_quo[DIV_LATENCY] : r_quo[DIV_LATENCY];
    end

endmodule

>>> sv/btpc_back.sv
// ----------------------------------------------------------------------------
// Back end of the compensation pipeline
// Second-order pressure correction, offset and saturation.
// ----------------------------------------------------------------------------
module btpc_back
    import btpc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_div_beat                 i_beat,
    input  logic [CAL_W-1:0]          i_cal_press_c,
    output logic                      o_vld,
    output logic signed [TEMP_W-1:0]  o_temp,
    output logic [PRES_W-1:0]         o_pres,
    output logic                      o_status
);

    logic [63:0] p7, p8, p9;
    assign p7 = {{48{i_cal_press_c[15]}}, i_cal_press_c[15:0]};
    assign p8 = {{48{i_cal_press_c[31]}}, i_cal_press_c[31:16]};
    assign p9 = {{48{i_cal_press_c[47]}}, i_cal_press_c[47:32]};

    // Stage A: q and the p8 product.
    logic        r_va, r_za;
    logic [TEMP_W-1:0] r_ta;
    logic [63:0] r_pa, r_qa, r_p8p;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_beat.vld;
        end
        r_za  <= i_beat.zero;
        r_ta  <= i_beat.temp;
        r_pa  <= i_beat.quo;
        r_qa  <= 64'($signed(i_beat.quo) >>> 13);
        r_p8p <= p8 * i_beat.quo;
    end

    // Stage B: p9 * q.
    logic        r_vb, r_zb;
    logic [TEMP_W-1:0] r_tb;
    logic [63:0] r_pb, r_qb, r_p9q, r_v2b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_zb  <= r_za;
        r_tb  <= r_ta;
        r_pb  <= r_pa;
        r_qb  <= r_qa;
        r_p9q <= p9 * r_qa;
        r_v2b <= 64'($signed(r_p8p) >>> 19);
    end

    // Stage C: partial products of p9 * q * q. Only the low 64 bits are kept,
    // so the high halves meet only in the cross terms.
    logic        r_vc, r_zc;
    logic [TEMP_W-1:0] r_tc;
    logic [63:0] r_pc, r_lo, r_v2c;
    logic [31:0] r_mid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_vb;
        end
        r_zc  <= r_zb;
        r_tc  <= r_tb;
        r_pc  <= r_pb;
        r_lo  <= {32'd0, r_p9q[31:0]} * {32'd0, r_qb[31:0]};
        r_mid <= r_p9q[63:32] * r_qb[31:0] + r_p9q[31:0] * r_qb[63:32];
        r_v2c <= r_v2b;
    end

    // Stage D: assemble p9 * q * q and scale it.
    logic        r_vd, r_zd;
    logic [TEMP_W-1:0] r_td;
    logic [63:0] r_pd, r_v1d, r_v2d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else begin
            r_vd <= r_vc;
        end
        r_zd  <= r_zc;
        r_td  <= r_tc;
        r_pd  <= r_pc;
        r_v1d <= 64'($signed(r_lo + {r_mid, 32'd0}) >>> 25);
        r_v2d <= r_v2c;
    end

    // Stage E: sum, offset, saturation.
    logic [63:0] n_p;
    assign n_p = 64'($signed(r_pd + r_v1d + r_v2d) >>> 8) + (p7 << 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_vd;
        end
        o_temp   <= r_td;
        o_status <= r_zd;
        if (r_zd || n_p[63]) begin
            o_pres <= '0;
        end else if (n_p > 64'd33554431) begin
            o_pres <= '1;
        end else begin
            o_pres <= n_p[PRES_W-1:0];
        end
    end

endmodule

>>> sv/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Fully pipelined integer compensation of raw temperature and pressure.
// ----------------------------------------------------------------------------
// One beat is taken per clock whenever i_start is high; o_busy is always low,
// because the pipeline never stalls. Every beat leaves exactly 76 cycles later
// as a one-cycle strobe on o_done, and the receiver must take it then: there
// is no backpressure. The latency is set by the six-stage front end, the
// 65-stage restoring divider (an entry stage for the magnitudes, then one
// quotient bit per stage for 64 stages) and five back-end stages. Calibration
// writes are always accepted, but must only be made while no beat is in
// flight, since the pipeline reads the live registers.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_defines.svh"
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [RAW_W-1:0]          i_pressure_raw,
    input  logic [RAW_W-1:0]          i_temperature_raw,
    output logic                      o_done,
    output logic signed [TEMP_W-1:0]  o_temp_centideg,
    output logic [PRES_W-1:0]         o_pressure_q24_8,
    output logic                      o_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [CAL_W-1:0]          i_cfg_data
);

    logic [CAL_W-1:0] r_cal_temp, r_cal_press_a, r_cal_press_b, r_cal_press_c;
    t_front_beat      front_beat;
    t_div_beat        div_beat;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Calibration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp    <= '0;
            r_cal_press_a <= '0;
            r_cal_press_b <= '0;
            r_cal_press_c <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CAL_TEMP:    r_cal_temp    <= i_cfg_data;
                REG_CAL_PRESS_A: r_cal_press_a <= i_cfg_data;
                REG_CAL_PRESS_B: r_cal_press_b <= i_cfg_data;
                REG_CAL_PRESS_C: r_cal_press_c <= i_cfg_data;
                default:         r_cal_temp    <= r_cal_temp;
            endcase
        end
    end

    btpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_vld             (i_start),
        .i_pressure_raw    (i_pressure_raw),
        .i_temperature_raw (i_temperature_raw),
        .i_cal_temp        (r_cal_temp),
        .i_cal_press_a     (r_cal_press_a),
        .i_cal_press_b     (r_cal_press_b),
        .o_beat            (front_beat)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (front_beat),
        .o_beat  (div_beat)
    );

    btpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (div_beat),
        .i_cal_press_c (r_cal_press_c),
        .o_vld         (o_done),
        .o_temp        (o_temp_centideg),
        .o_pres        (o_pressure_q24_8),
        .o_status      (o_status)
    );

    // A zero divisor always reports zero pressure.
    `BTPC_ASSERT_IMP(a_zero_pres, i_clk, i_rst_n, o_done && o_status, o_pressure_q24_8 == '0)
    // A beat leaving the front end enters the divider on the next cycle.
    `BTPC_ASSERT_NXT(a_front_next, i_clk, i_rst_n, front_beat.vld, u_div.r_vld[0])
    // A result strobe follows a beat leaving the divider after the back-end depth.
    `BTPC_ASSERT_IMP(a_div_to_out, i_clk, i_rst_n, div_beat.vld, ##5 o_done)

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench of the barometric temperature and pressure compensation
// Drives raw converter pairs under several calibration settings. Every result
// beat is checked against the stored result of a known row, else against a bit-accurate predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import btpc_pkg::*;

    // Fields of one compensated result.
    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
        logic                     status;
    } t_comp;

    // One row of the directed stimulus. Rows marked known carry their result;
    // all other rows are checked against the predictor.
    typedef struct {
        int                       cal_set;
        logic [RAW_W-1:0]         p_raw;
        logic [RAW_W-1:0]         t_raw;
        bit                       known;
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
        logic                     status;
    } t_row;

    localparam int NUM_ROWS = 21;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_ITEMS = 100;
    // Beat latency of the pipeline plus some margin.
    localparam int DRAIN_CYCLES = 90;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [RAW_W-1:0]         i_pressure_raw;
    logic [RAW_W-1:0]         i_temperature_raw;
    logic                     o_done;
    logic signed [TEMP_W-1:0] o_temp_centideg;
    logic [PRES_W-1:0]        o_pressure_q24_8;
    logic                     o_status;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [IDX_W-1:0]         i_cfg_index;
    logic [CAL_W-1:0]         i_cfg_data;

    // Expected result that travels alongside the input beat on i_start.
    t_comp                    staged_result;

    logic [CAL_W-1:0]         cal_regs [4];
    logic [CAL_W-1:0]         cal_sets [5][4];
    t_comp                    pending_results [$];
    t_row                     rows [NUM_ROWS];
    int                       error_count;
    int                       result_count;
    int                       zero_div_count;

    baro_temp_pressure_compensation u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_pressure_raw    (i_pressure_raw),
        .i_temperature_raw (i_temperature_raw),
        .o_done            (o_done),
        .o_temp_centideg   (o_temp_centideg),
        .o_pressure_q24_8  (o_pressure_q24_8),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shifts are wrapped in functions so that their signedness cannot be
    // changed by the surrounding unsigned expression.
    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Signed division truncating toward zero; the most negative value over
    // minus one wraps to itself, as the magnitude form gives naturally.
    function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] ^ d[63]) ? -q : q;
    endfunction

    // Integer compensation of one raw pair under the current calibration.
    function automatic t_comp compensate(input logic [RAW_W-1:0] adc_p,
                                         input logic [RAW_W-1:0] adc_t);
        logic [31:0] t1, t2, t3, a, d, tv1, tv2, tfine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] tf, tc, v1, v2, p, q, num;
        t_comp r;
        t1 = {16'd0, cal_regs[REG_CAL_TEMP][15:0]};
        t2 = 32'(sx16(cal_regs[REG_CAL_TEMP][31:16]));
        t3 = 32'(sx16(cal_regs[REG_CAL_TEMP][47:32]));
        p1 = {48'd0, cal_regs[REG_CAL_PRESS_A][15:0]};
        p2 = sx16(cal_regs[REG_CAL_PRESS_A][31:16]);
        p3 = sx16(cal_regs[REG_CAL_PRESS_A][47:32]);
        p4 = sx16(cal_regs[REG_CAL_PRESS_B][15:0]);
        p5 = sx16(cal_regs[REG_CAL_PRESS_B][31:16]);
        p6 = sx16(cal_regs[REG_CAL_PRESS_B][47:32]);
        p7 = sx16(cal_regs[REG_CAL_PRESS_C][15:0]);
        p8 = sx16(cal_regs[REG_CAL_PRESS_C][31:16]);
        p9 = sx16(cal_regs[REG_CAL_PRESS_C][47:32]);

        // Fine temperature wraps at 32 bits.
        a = {15'd0, adc_t[19:3]} - (t1 << 1);
        tv1 = asr32(a * t2, 11);
        d = {16'd0, adc_t[19:4]} - t1;
        tv2 = asr32(asr32(d * d, 12) * t3, 14);
        tfine = tv1 + tv2;
        tf = {{32{tfine[31]}}, tfine};

        // The scaled temperature is formed at 64 bits and then saturated.
        tc = asr64(tf * 64'd5 + 64'd128, 8);
        if ($signed(tc) > 64'sd32767) r.temp = 16'sh7FFF;
        else if ($signed(tc) < -64'sd32768) r.temp = 16'sh8000;
        else r.temp = tc[15:0];

        v1 = tf - 64'd128000;
        v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);

        if (v1 == 64'd0) begin
            r.pres = '0;
            r.status = 1'b1;
            return r;
        end

        p = 64'd1048576 - {44'd0, adc_p};
        num = ((p << 31) - v2) * 64'd3125;
        p = div_trunc(num, v1);
        q = asr64(p, 13);
        v1 = asr64(p9 * q * q, 25);
        v2 = asr64(p8 * p, 19);
        p = asr64(p + v1 + v2, 8) + (p7 << 4);

        if ($signed(p) < 64'sd0) r.pres = '0;
        else if ($signed(p) > 64'sd33554431) r.pres = '1;
        else r.pres = p[PRES_W-1:0];
        r.status = 1'b0;
        return r;
    endfunction

    // Accepted input beats queue their expectation; result beats are checked
    // against the oldest one.
    always @(posedge i_clk) begin
        t_comp want;
        if (i_rst_n && i_start && !o_busy) begin
            pending_results.push_back(staged_result);
        end
        if (i_rst_n && o_done) begin
            result_count++;
            if (o_status) zero_div_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: temp %0d pres %0d status %0d",
                         $time, o_temp_centideg, o_pressure_q24_8, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_temp_centideg !== want.temp) begin
                    $display("%0t: temp mismatch: expected %0d, actual %0d",
                             $time, want.temp, o_temp_centideg);
                    error_count++;
                end
                if (o_pressure_q24_8 !== want.pres) begin
                    $display("%0t: pressure mismatch: expected %0d, actual %0d",
                             $time, want.pres, o_pressure_q24_8);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Present one raw pair and hold it until accepted; an idle burst may follow.
    task automatic send_pair(input logic [RAW_W-1:0] p_raw, input logic [RAW_W-1:0] t_raw,
                             input t_comp want, input bit allow_idle);
        i_start <= 1'b1;
        i_pressure_raw <= p_raw;
        i_temperature_raw <= t_raw;
        staged_result <= want;
        do @(posedge i_clk); while (o_busy);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected result has come back,
    // then let the pipeline drain.
    task automatic drain_pipeline();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the valid line drops after it before the next write.
    task automatic write_cal(input t_reg_idx idx, input logic [CAL_W-1:0] value);
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 6)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cal_regs[idx] = value;
        @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [CAL_W-1:0] regs [4]);
        write_cal(REG_CAL_TEMP, regs[0]);
        write_cal(REG_CAL_PRESS_A, regs[1]);
        write_cal(REG_CAL_PRESS_B, regs[2]);
        write_cal(REG_CAL_PRESS_C, regs[3]);
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] v);
        return v + 16'($urandom_range(0, 511)) - 16'd256;
    endfunction

    function automatic logic [CAL_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Random calibration: mostly near a realistic part, sometimes raw noise,
    // sometimes with P1 cleared so that the divisor is zero.
    task automatic random_cal(input int mode, output logic [CAL_W-1:0] regs [4]);
        for (int i = 0; i < 4; i++) begin
            regs[i] = {jitter(cal_sets[1][i][47:32]), jitter(cal_sets[1][i][31:16]),
                       jitter(cal_sets[1][i][15:0])};
            if (mode == 1) regs[i] = rand48();
        end
        if (mode == 2) regs[1][15:0] = 16'd0;
    endtask

    function automatic logic [RAW_W-1:0] random_raw(input logic [RAW_W-1:0] center);
        if ($urandom_range(0, 1)) return RAW_W'($urandom_range(0, 20'hFFFFF));
        return center + RAW_W'($urandom_range(0, 65535)) - 20'd32768;
    endfunction

    initial begin
        logic [CAL_W-1:0] regs [4];
        t_comp want;
        int cur_set;
        int mode;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_pressure_raw = '0;
        i_temperature_raw = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_CAL_TEMP;
        i_cfg_data = '0;
        staged_result = '{temp: '0, pres: '0, status: 1'b0};
        error_count = 0;
        result_count = 0;
        zero_div_count = 0;
        for (int i = 0; i < 4; i++) cal_regs[i] = '0;

        // Set 0 is the reset state, set 1 a realistic part, set 2 all ones,
        // set 3 the signed extremes, set 4 the realistic part with P1 cleared.
        cal_sets[0] = '{48'h0, 48'h0, 48'h0, 48'h0};
        cal_sets[1] = '{48'hFC18_6743_6B70, 48'h0BD0_D643_8E7D,
                        48'hFFF9_008C_0B27, 48'h1770_C6F8_3C8C};
        cal_sets[2] = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                        48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
        cal_sets[3] = '{48'h8000_7FFF_FFFF, 48'h7FFF_8000_FFFF,
                        48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF};
        cal_sets[4] = '{48'hFC18_6743_6B70, 48'h0BD0_D643_0000,
                        48'hFFF9_008C_0B27, 48'h1770_C6F8_3C8C};

        // With all coefficients zero the fine temperature is zero and the
        // divisor vanishes, so every pair reads 0 degrees and a zero divisor.
        rows = '{
            '{0, 20'h00000, 20'h00000, 1, 16'sd0, 25'd0, 1'b1},
            '{0, 20'hFFFFF, 20'hFFFFF, 1, 16'sd0, 25'd0, 1'b1},
            '{0, 20'h00000, 20'hFFFFF, 1, 16'sd0, 25'd0, 1'b1},
            '{0, 20'hFFFFF, 20'h00000, 1, 16'sd0, 25'd0, 1'b1},
            '{0, 20'h655AC, 20'h7EED0, 1, 16'sd0, 25'd0, 1'b1},
            '{1, 20'h655AC, 20'h7EED0, 0, 16'sd0, 25'd0, 1'b0},
            '{1, 20'h00000, 20'h00000, 0, 16'sd0, 25'd0, 1'b0},
            '{1, 20'hFFFFF, 20'hFFFFF, 0, 16'sd0, 25'd0, 1'b0},
            '{1, 20'h00000, 20'hFFFFF, 0, 16'sd0, 25'd0, 1'b0},
            '{1, 20'hFFFFF, 20'h00000, 0, 16'sd0, 25'd0, 1'b0},
            '{1, 20'h55555, 20'hAAAAA, 0, 16'sd0, 25'd0, 1'b0},
            '{1, 20'hAAAAA, 20'h55555, 0, 16'sd0, 25'd0, 1'b0},
            '{2, 20'h00000, 20'h00000, 0, 16'sd0, 25'd0, 1'b0},
            '{2, 20'hFFFFF, 20'hFFFFF, 0, 16'sd0, 25'd0, 1'b0},
            '{2, 20'h655AC, 20'h7EED0, 0, 16'sd0, 25'd0, 1'b0},
            '{3, 20'h00000, 20'hFFFFF, 0, 16'sd0, 25'd0, 1'b0},
            '{3, 20'hFFFFF, 20'h00000, 0, 16'sd0, 25'd0, 1'b0},
            '{3, 20'h655AC, 20'h7EED0, 0, 16'sd0, 25'd0, 1'b0},
            '{4, 20'h655AC, 20'h7EED0, 0, 16'sd0, 25'd0, 1'b0},
            '{4, 20'hFFFFF, 20'h00000, 0, 16'sd0, 25'd0, 1'b0},
            '{4, 20'h00000, 20'hFFFFF, 0, 16'sd0, 25'd0, 1'b0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: switch calibration only between drained groups.
        cur_set = 0;
        foreach (rows[i]) begin
            if (rows[i].cal_set != cur_set) begin
                drain_pipeline();
                cur_set = rows[i].cal_set;
                load_cal(cal_sets[cur_set]);
            end
            if (rows[i].known)
                want = '{temp: rows[i].temp, pres: rows[i].pres, status: rows[i].status};
            else
                want = compensate(rows[i].p_raw, rows[i].t_raw);
            send_pair(rows[i].p_raw, rows[i].t_raw, want, 1'b1);
        end

        // Random part: one calibration per phase, the last phase back to back.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipeline();
            mode = (ph == 3 || ph == 7) ? 1 : (ph == 5) ? 2 : 0;
            random_cal(mode, regs);
            load_cal(regs);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                logic [RAW_W-1:0] p_raw;
                logic [RAW_W-1:0] t_raw;
                // Once in the run the sender holds off until the pipeline is empty.
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_pipeline();
                p_raw = random_raw(20'h655AC);
                t_raw = random_raw(20'h7EED0);
                send_pair(p_raw, t_raw, compensate(p_raw, t_raw), ph != NUM_PHASES - 1);
            end
        end

        drain_pipeline();
        $display("Checked %0d result beats (%0d with a zero divisor) over %0d calibrations.",
                 result_count, zero_div_count, 5 + NUM_PHASES);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, pending_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
